>>> hw/rtl/stsum_pkg.sv
// stsum_pkg: shared widths, control word layout and microcode ROM for the
// segment tree range-sum block. No dependencies; used by stsum_seq, stsum_dp
// and the top level.
package stsum_pkg;

	localparam int SUM_BITS       = 26;
	localparam int POS_BITS       = 11;
	localparam int WVAL_BITS      = 16;
	localparam int IN_DATA_BITS   = 56;
	localparam int OUT_DATA_BITS  = 32;
	localparam int LEAVES_DEF     = 1024;
	localparam int VALUE_BITS_DEF = 16;

	// sequencer steps (microcode addresses)
	typedef enum logic [3:0] {
		S_CLEAR    = 4'd0,
		S_IDLE     = 4'd1,
		S_DISPATCH = 4'd2,
		S_WCHECK   = 4'd3,
		S_WLEAF    = 4'd4,
		S_WCLIMB   = 4'd5,
		S_WSIB     = 4'd6,
		S_QLOAD    = 4'd7,
		S_QREADL   = 4'd8,
		S_QADDL    = 4'd9,
		S_QADDR    = 4'd10,
		S_EMIT     = 4'd11
	} step_t;

	// memory read address source
	typedef enum logic [2:0] {
		RD_NONE,
		RD_LEAF_SIB,
		RD_SIB,
		RD_L,
		RD_RM1,
		RD_LNEXT
	} rd_sel_t;

	// memory write source
	typedef enum logic [1:0] {
		WR_NONE,
		WR_CLR,
		WR_LEAF,
		WR_PARENT
	} wr_sel_t;

	// datapath register action
	typedef enum logic [2:0] {
		ACT_NOP,
		ACT_CLR_INC,
		ACT_TAKE,
		ACT_LOAD_W,
		ACT_CLIMB,
		ACT_LOAD_Q,
		ACT_ADD_L,
		ACT_ADD_R
	} act_t;

	// EMIT is signaled by its own bit so the action set stays at eight
	typedef enum logic [1:0] {
		J_NEXT,
		J_GOTO,
		J_IF,
		J_WAIT
	} jmp_t;

	typedef enum logic [2:0] {
		COND_IN,
		COND_QUERY,
		COND_BADPOS,
		COND_AT_TOP,
		COND_EMPTY,
		COND_MORE,
		COND_OUT_FREE,
		COND_CLR_LAST
	} cond_t;

	typedef struct packed {
		rd_sel_t rd;
		wr_sel_t wr;
		act_t    act;
		logic    emit;
		jmp_t    jmp;
		cond_t   cond;
		step_t   target;
	} ctrl_t;

	typedef struct packed {
		logic clr_last;
		logic query;
		logic bad_pos;
		logic at_top;
		logic empty;
		logic more;
		logic out_free;
	} status_t;

	function automatic ctrl_t mk(rd_sel_t rd, wr_sel_t wr, act_t act, logic emit,
			jmp_t jmp, cond_t cond, step_t target);
		ctrl_t c;
		c.rd     = rd;
		c.wr     = wr;
		c.act    = act;
		c.emit   = emit;
		c.jmp    = jmp;
		c.cond   = cond;
		c.target = target;
		return c;
	endfunction

	// microcode ROM
	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		unique case (s)
			S_CLEAR:    c = mk(RD_NONE, WR_CLR, ACT_CLR_INC, 1'b0, J_WAIT, COND_CLR_LAST, S_IDLE);
			S_IDLE:     c = mk(RD_NONE, WR_NONE, ACT_TAKE, 1'b0, J_WAIT, COND_IN, S_DISPATCH);
			S_DISPATCH: c = mk(RD_NONE, WR_NONE, ACT_NOP, 1'b0, J_IF, COND_QUERY, S_QLOAD);
			S_WCHECK:   c = mk(RD_NONE, WR_NONE, ACT_NOP, 1'b0, J_IF, COND_BADPOS, S_IDLE);
			S_WLEAF:    c = mk(RD_LEAF_SIB, WR_LEAF, ACT_LOAD_W, 1'b0, J_NEXT, COND_IN, S_IDLE);
			S_WCLIMB:   c = mk(RD_NONE, WR_PARENT, ACT_CLIMB, 1'b0, J_IF, COND_AT_TOP, S_IDLE);
			S_WSIB:     c = mk(RD_SIB, WR_NONE, ACT_NOP, 1'b0, J_GOTO, COND_IN, S_WCLIMB);
			S_QLOAD:    c = mk(RD_NONE, WR_NONE, ACT_LOAD_Q, 1'b0, J_IF, COND_EMPTY, S_EMIT);
			S_QREADL:   c = mk(RD_L, WR_NONE, ACT_NOP, 1'b0, J_NEXT, COND_IN, S_IDLE);
			S_QADDL:    c = mk(RD_RM1, WR_NONE, ACT_ADD_L, 1'b0, J_NEXT, COND_IN, S_IDLE);
			S_QADDR:    c = mk(RD_LNEXT, WR_NONE, ACT_ADD_R, 1'b0, J_IF, COND_MORE, S_QADDL);
			S_EMIT:     c = mk(RD_NONE, WR_NONE, ACT_NOP, 1'b1, J_WAIT, COND_OUT_FREE, S_IDLE);
			default:    c = mk(RD_NONE, WR_NONE, ACT_NOP, 1'b0, J_GOTO, COND_IN, S_IDLE);
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/stsum_seq.sv
// stsum_seq: step counter and microcode fetch with conditional jumps.
// Depends on stsum_pkg (control word, status struct, ROM).
module stsum_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  stsum_pkg::status_t status,
	output stsum_pkg::ctrl_t   ctrl
);

	stsum_pkg::step_t step_q;
	stsum_pkg::step_t step_next;
	stsum_pkg::step_t step_inc;
	logic             cond;

	assign ctrl     = stsum_pkg::ucode(step_q);
	assign step_inc = stsum_pkg::step_t'(step_q + 4'd1);

	always_comb begin
		unique case (ctrl.cond)
			stsum_pkg::COND_IN:       cond = in_valid;
			stsum_pkg::COND_QUERY:    cond = status.query;
			stsum_pkg::COND_BADPOS:   cond = status.bad_pos;
			stsum_pkg::COND_AT_TOP:   cond = status.at_top;
			stsum_pkg::COND_EMPTY:    cond = status.empty;
			stsum_pkg::COND_MORE:     cond = status.more;
			stsum_pkg::COND_OUT_FREE: cond = status.out_free;
			stsum_pkg::COND_CLR_LAST: cond = status.clr_last;
			default:                  cond = 1'b0;
		endcase
	end

	always_comb begin
		unique case (ctrl.jmp)
			stsum_pkg::J_NEXT: step_next = step_inc;
			stsum_pkg::J_GOTO: step_next = ctrl.target;
			stsum_pkg::J_IF:   step_next = cond ? ctrl.target : step_inc;
			stsum_pkg::J_WAIT: step_next = cond ? ctrl.target : step_q;
			default:           step_next = stsum_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= stsum_pkg::S_CLEAR;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

>>> hw/rtl/stsum_dp.sv
// stsum_dp: node-sum memory, index and accumulator registers, output word.
// Depends on stsum_pkg; driven by the control word from stsum_seq.
module stsum_dp #(
	parameter int LEAVES     = stsum_pkg::LEAVES_DEF,
	parameter int VALUE_BITS = stsum_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  stsum_pkg::ctrl_t                   ctrl,
	input  logic                               in_valid,
	input  logic                               in_op,
	input  logic [stsum_pkg::POS_BITS-1:0]     in_position,
	input  logic [stsum_pkg::WVAL_BITS-1:0]    in_write_value,
	input  logic [stsum_pkg::POS_BITS-1:0]     in_range_low,
	input  logic [stsum_pkg::POS_BITS-1:0]     in_range_high,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [stsum_pkg::SUM_BITS-1:0]     out_range_sum,
	output stsum_pkg::status_t                 status
);

	localparam int SPAN_BITS = $clog2(LEAVES);
	localparam int SPAN      = 1 << SPAN_BITS;
	localparam int NB        = SPAN_BITS + 1;
	localparam int IW        = SPAN_BITS + 2;
	localparam int VB        = (VALUE_BITS < stsum_pkg::WVAL_BITS) ? VALUE_BITS
		: stsum_pkg::WVAL_BITS;
	localparam logic [stsum_pkg::WVAL_BITS-1:0] VMASK =
		stsum_pkg::WVAL_BITS'((64'd1 << VB) - 64'd1);
	localparam int SB = stsum_pkg::SUM_BITS;

	logic [SB-1:0] mem [2*SPAN];

	logic                              op_q;
	logic [stsum_pkg::POS_BITS-1:0]    pos_q;
	logic [stsum_pkg::WVAL_BITS-1:0]   wval_q;
	logic [stsum_pkg::POS_BITS-1:0]    lo_q;
	logic [stsum_pkg::POS_BITS-1:0]    hi_q;
	logic [NB-1:0]                     k_q;
	logic [NB-1:0]                     clr_q;
	logic [IW-1:0]                     l_q;
	logic [IW-1:0]                     r_q;
	logic [SB-1:0]                     acc_q;
	logic [SB-1:0]                     rd_q;
	logic                              out_valid_q;
	logic [SB-1:0]                     out_data_q;

	logic [31:0]   pos_m1;
	logic [NB-1:0] leaf;
	logic [SB-1:0] leaf_val;
	logic [31:0]   lo_c;
	logic [31:0]   hi_c;
	logic [IW-1:0] l_load;
	logic [IW-1:0] r_load;
	logic [IW-1:0] l_next;
	logic [IW-1:0] r_next;
	logic [SB-1:0] acc_plus;
	logic          take;
	logic          out_free;
	logic          we;
	logic [NB-1:0] waddr;
	logic [SB-1:0] wdata;
	logic [NB-1:0] raddr;

	assign pos_m1   = 32'(pos_q) - 32'd1;
	assign leaf     = {1'b1, pos_m1[SPAN_BITS-1:0]};
	assign leaf_val = SB'(wval_q & VMASK);

	// clamp the query bounds to the positions that exist
	assign lo_c   = (lo_q == '0) ? 32'd1 : 32'(lo_q);
	assign hi_c   = (32'(hi_q) > 32'(LEAVES + 1)) ? 32'(LEAVES + 1) : 32'(hi_q);
	assign l_load = IW'(lo_c - 32'd1 + 32'(SPAN));
	assign r_load = IW'(hi_c - 32'd1 + 32'(SPAN));
	assign l_next = (l_q + IW'(l_q[0])) >> 1;
	assign r_next = r_q >> 1;

	assign acc_plus = acc_q + rd_q;
	assign take     = (ctrl.act == stsum_pkg::ACT_TAKE) && in_valid;
	assign out_free = !out_valid_q || out_ready;

	assign status.clr_last = &clr_q;
	assign status.query    = op_q;
	assign status.bad_pos  = (pos_q == '0) || (32'(pos_q) > 32'(LEAVES));
	assign status.at_top   = (k_q >> 1) == NB'(1);
	assign status.empty    = hi_c <= lo_c;
	assign status.more     = l_next < r_next;
	assign status.out_free = out_free;

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		case (ctrl.wr)
			stsum_pkg::WR_CLR: begin
				we = 1'b1;
			end
			stsum_pkg::WR_LEAF: begin
				we    = 1'b1;
				waddr = leaf;
				wdata = leaf_val;
			end
			stsum_pkg::WR_PARENT: begin
				we    = 1'b1;
				waddr = k_q >> 1;
				wdata = acc_plus;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (ctrl.rd)
			stsum_pkg::RD_LEAF_SIB: raddr = leaf ^ NB'(1);
			stsum_pkg::RD_SIB:      raddr = k_q ^ NB'(1);
			stsum_pkg::RD_L:        raddr = l_q[NB-1:0];
			stsum_pkg::RD_RM1:      raddr = NB'(r_q - IW'(1));
			stsum_pkg::RD_LNEXT:    raddr = l_next[NB-1:0];
			default:                raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= in_op;
			pos_q  <= in_position;
			wval_q <= in_write_value;
			lo_q   <= in_range_low;
			hi_q   <= in_range_high;
		end
		case (ctrl.act)
			stsum_pkg::ACT_LOAD_W: begin
				k_q   <= leaf;
				acc_q <= leaf_val;
			end
			stsum_pkg::ACT_CLIMB: begin
				k_q   <= k_q >> 1;
				acc_q <= acc_plus;
			end
			stsum_pkg::ACT_LOAD_Q: begin
				l_q   <= l_load;
				r_q   <= r_load;
				acc_q <= '0;
			end
			stsum_pkg::ACT_ADD_L: begin
				if (l_q[0]) begin
					acc_q <= acc_plus;
				end
			end
			stsum_pkg::ACT_ADD_R: begin
				if (r_q[0]) begin
					acc_q <= acc_plus;
				end
				l_q <= l_next;
				r_q <= r_next;
			end
			default: begin
			end
		endcase
		if (ctrl.emit && out_free) begin
			out_data_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.act == stsum_pkg::ACT_CLR_INC) begin
				clr_q <= clr_q + NB'(1);
			end
			if (ctrl.emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_range_sum = out_data_q;

endmodule

>>> hw/rtl/segment_tree_point_set_range_sum.sv
// Segment tree, point set / range sum, run by a microcoded sequencer over one node memory.
// Write: one memory read and one write per tree level, two steps per level.
// Reset: async, active low; a clearing pass then zeroes all 2*SPAN nodes, one per
// cycle, with s_tready low until it ends.
module segment_tree_point_set_range_sum #(
	parameter int LEAVES     = stsum_pkg::LEAVES_DEF,
	parameter int VALUE_BITS = stsum_pkg::VALUE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input word
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [10:0] position, [26:11] write_value, [37:27] range_low,
	// [48:38] range_high, [55:49] zero
	input  logic [stsum_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// [0] op: 0 = set a position, 1 = range sum query
	input  logic                                  s_tuser,
	// result word
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [25:0] range_sum, [31:26] zero
	output logic [stsum_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

	stsum_pkg::ctrl_t   ctrl;
	stsum_pkg::status_t status;
	logic [stsum_pkg::SUM_BITS-1:0] range_sum;

	// ready only in the idle step; a waiting result does not block it
	assign s_tready = (ctrl.act == stsum_pkg::ACT_TAKE);

	stsum_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.ctrl     (ctrl)
	);

	stsum_dp #(
		.LEAVES     (LEAVES),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.in_valid       (s_tvalid),
		.in_op          (s_tuser),
		.in_position    (s_tdata[10:0]),
		.in_write_value (s_tdata[26:11]),
		.in_range_low   (s_tdata[37:27]),
		.in_range_high  (s_tdata[48:38]),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_range_sum  (range_sum),
		.status         (status)
	);

	// zero-pad the sum to a whole number of bytes
	assign m_tdata = stsum_pkg::OUT_DATA_BITS'(range_sum);

endmodule

>>> tb/segment_tree_point_set_range_sum_test.sv
// Self-checking bench for segment_tree_point_set_range_sum: point writes and range-sum
// queries over the input stream, results checked against a behavioral tree kept here.
// Depends on stsum_pkg and the segment_tree_point_set_range_sum RTL.
module segment_tree_point_set_range_sum_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEAVES     = stsum_pkg::LEAVES_DEF;
	localparam int VALUE_BITS = stsum_pkg::VALUE_BITS_DEF;
	localparam int SUM_BITS   = stsum_pkg::SUM_BITS;
	localparam int POS_BITS   = stsum_pkg::POS_BITS;
	localparam int WVAL_BITS  = stsum_pkg::WVAL_BITS;
	// leaves sit at the next power of two, root at node 1
	localparam int SPAN       = 1 << $clog2(LEAVES);
	localparam int NODES      = 2 * SPAN;
	localparam int PAD_BITS   = stsum_pkg::IN_DATA_BITS - (3 * POS_BITS + WVAL_BITS);

	// op code carried on s_tuser
	typedef enum logic {
		OP_SET   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// one row of the directed part; fixed_sum is used only when has_fixed is set
	typedef struct packed {
		op_t                  op;
		logic [POS_BITS-1:0]  pos;
		logic [WVAL_BITS-1:0] wval;
		logic [POS_BITS-1:0]  lo;
		logic [POS_BITS-1:0]  hi;
		logic                 has_fixed;
		logic [SUM_BITS-1:0]  fixed_sum;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 21;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// whole range straight after reset: everything cleared
		'{OP_QUERY, 11'd0,    16'h0000, 11'd1,    11'd1025, 1'b1, 26'd0},
		// both end leaves at full scale
		'{OP_SET,   11'd1,    16'hFFFF, 11'd0,    11'd0,    1'b0, 26'd0},
		'{OP_SET,   11'd1024, 16'hFFFF, 11'd0,    11'd0,    1'b0, 26'd0},
		// out-of-range positions: dropped, tree untouched
		'{OP_SET,   11'd0,    16'h1234, 11'd0,    11'd0,    1'b0, 26'd0},
		'{OP_SET,   11'd1025, 16'h5A5A, 11'd0,    11'd0,    1'b0, 26'd0},
		'{OP_SET,   11'd2047, 16'hFFFF, 11'd2047, 11'd2047, 1'b0, 26'd0},
		'{OP_QUERY, 11'd0,    16'h0000, 11'd1,    11'd1025, 1'b1, 26'd131070},
		// low bound of zero and high bound far past the end: clamped
		'{OP_QUERY, 11'd0,    16'h0000, 11'd0,    11'd2047, 1'b1, 26'd131070},
		// empty range, query ignores the write fields
		'{OP_QUERY, 11'd2047, 16'hFFFF, 11'd5,    11'd5,    1'b1, 26'd0},
		// reversed range
		'{OP_QUERY, 11'd0,    16'h0000, 11'd10,   11'd3,    1'b1, 26'd0},
		// low bound past the end
		'{OP_QUERY, 11'd0,    16'h0000, 11'd1025, 11'd2047, 1'b1, 26'd0},
		'{OP_QUERY, 11'd0,    16'h0000, 11'd2047, 11'd1,    1'b1, 26'd0},
		'{OP_QUERY, 11'd0,    16'h0000, 11'd0,    11'd0,    1'b1, 26'd0},
		// single-leaf ranges at both ends
		'{OP_QUERY, 11'd0,    16'h0000, 11'd1024, 11'd1025, 1'b1, 26'd65535},
		'{OP_QUERY, 11'd0,    16'h0000, 11'd1,    11'd2,    1'b1, 26'd65535},
		// neighbors across the middle split of the tree
		'{OP_SET,   11'd512,  16'h0001, 11'd2047, 11'd2047, 1'b0, 26'd0},
		'{OP_SET,   11'd513,  16'h8000, 11'd0,    11'd0,    1'b0, 26'd0},
		'{OP_QUERY, 11'd0,    16'h0000, 11'd2,    11'd1024, 1'b0, 26'd0},
		'{OP_QUERY, 11'd0,    16'h0000, 11'd512,  11'd514,  1'b0, 26'd0},
		// overwrite a leaf with zero
		'{OP_SET,   11'd1,    16'h0000, 11'd0,    11'd0,    1'b0, 26'd0},
		'{OP_QUERY, 11'd0,    16'h0000, 11'd1,    11'd1025, 1'b0, 26'd0}
	};

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [stsum_pkg::IN_DATA_BITS-1:0]  s_tdata = '0;
	logic                                s_tuser = 1'b0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [stsum_pkg::OUT_DATA_BITS-1:0] m_tdata;

	// behavioral copy of the node memory
	logic [SUM_BITS-1:0] tree_sums [NODES];
	// range sums still owed by the block, oldest first
	logic [SUM_BITS-1:0] expected_sums [$];
	logic [SUM_BITS-1:0] want_sum;
	int                  mismatches = 0;
	// set for stretches where neither side inserts idle cycles
	bit                  quiet = 1'b0;

	segment_tree_point_set_range_sum #(
		.LEAVES     (LEAVES),
		.VALUE_BITS (VALUE_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Store a value at one leaf and rebuild every ancestor up to the root.
	function automatic void apply_point_set(logic [POS_BITS-1:0] pos, logic [WVAL_BITS-1:0] wval);
		int unsigned    k;
		longint unsigned vmask;
		vmask = (64'd1 << VALUE_BITS) - 64'd1;
		if (pos < 1 || pos > LEAVES)
			return;
		k = pos - 1 + SPAN;
		tree_sums[k] = SUM_BITS'(longint'(wval) & vmask);
		k = k >> 1;
		while (k != 0) begin
			tree_sums[k] = tree_sums[2 * k] + tree_sums[2 * k + 1];
			k = k >> 1;
		end
	endfunction

	// Sum over [lo, hi) by the usual bottom-up walk, both bounds clamped first.
	function automatic logic [SUM_BITS-1:0] range_total(logic [POS_BITS-1:0] lo_in,
			logic [POS_BITS-1:0] hi_in);
		int unsigned         lo;
		int unsigned         hi;
		int unsigned         l;
		int unsigned         r;
		logic [SUM_BITS-1:0] acc;
		lo = lo_in;
		hi = hi_in;
		acc = '0;
		if (lo < 1)
			lo = 1;
		if (hi > LEAVES + 1)
			hi = LEAVES + 1;
		if (hi <= lo)
			return '0;
		l = lo - 1 + SPAN;
		r = hi - 1 + SPAN;
		while (l < r) begin
			if (l % 2 == 1) begin
				acc = acc + tree_sums[l];
				l = l + 1;
			end
			if (r % 2 == 1) begin
				r = r - 1;
				acc = acc + tree_sums[r];
			end
			l = l >> 1;
			r = r >> 1;
		end
		return acc;
	endfunction

	// Offer one word after a random gap, hold it until taken, then update the
	// behavioral tree or queue the owed sum. A fixed sum replaces the prediction.
	task automatic send_word(op_t op, logic [POS_BITS-1:0] pos, logic [WVAL_BITS-1:0] wval,
			logic [POS_BITS-1:0] lo, logic [POS_BITS-1:0] hi, logic has_fixed,
			logic [SUM_BITS-1:0] fixed_sum);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		// lower valid only for a real gap, so back-to-back words keep it high
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{PAD_BITS{1'b0}}, hi, lo, wval, pos};
		do @(posedge clk); while (s_tready !== 1'b1);
		if (op == OP_SET)
			apply_point_set(pos, wval);
		else
			expected_sums.insert(expected_sums.size(),
				has_fixed ? fixed_sum : range_total(lo, hi));
	endtask

	// Result side: after each taken word, drop ready for a random number of cycles.
	initial begin
		int pause;
		wait (arst_n === 1'b1);
		@(posedge clk);
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready) begin
				pause = quiet ? 0 : $urandom_range(0, 16);
				if (pause != 0) begin
					m_tready <= 1'b0;
					repeat (pause) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Compare every taken result word with the oldest owed sum.
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready) begin
			if (expected_sums.size() == 0) begin
				$error("range_sum: expected none, actual %0d", m_tdata[SUM_BITS-1:0]);
				mismatches++;
			end else begin
				want_sum = expected_sums.pop_front();
				if (m_tdata[SUM_BITS-1:0] !== want_sum) begin
					$error("range_sum: expected %0d, actual %0d", want_sum,
						m_tdata[SUM_BITS-1:0]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		op_t                  op;
		logic [POS_BITS-1:0]  pos;
		logic [WVAL_BITS-1:0] wval;
		logic [POS_BITS-1:0]  lo;
		logic [POS_BITS-1:0]  hi;
		int                   pick;
		for (int i = 0; i < NODES; i++)
			tree_sums[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part: the block holds s_tready low through its clearing pass
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_word(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].wval,
				directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].has_fixed,
				directed_rows[i].fixed_sum);

		// random part, checked against the predictor
		for (int n = 0; n < 750; n++) begin
			// switch between idle-free stretches and random gaps now and then
			if (n % 64 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			op = op_t'($urandom_range(0, 1));

			pick = $urandom_range(0, 9);
			if (pick == 0)
				pos = POS_BITS'($urandom_range(0, 2047));
			else if (pick == 1)
				pos = ($urandom_range(0, 1) == 0) ? POS_BITS'(1) : POS_BITS'(LEAVES);
			else
				pos = POS_BITS'($urandom_range(1, LEAVES));

			pick = $urandom_range(0, 9);
			if (pick == 0)
				wval = '0;
			else if (pick == 1)
				wval = '1;
			else
				wval = WVAL_BITS'($urandom_range(0, 65535));

			pick = $urandom_range(0, 19);
			if (pick < 3) begin
				// anything the field width allows
				lo = POS_BITS'($urandom_range(0, 2047));
				hi = POS_BITS'($urandom_range(0, 2047));
			end else if (pick < 6) begin
				// bounds at and around the edges
				case ($urandom_range(0, 3))
					0: lo = '0;
					1: lo = POS_BITS'(1);
					2: lo = POS_BITS'(LEAVES);
					default: lo = POS_BITS'(LEAVES + 1);
				endcase
				case ($urandom_range(0, 3))
					0: hi = '0;
					1: hi = POS_BITS'(1);
					2: hi = POS_BITS'(LEAVES + 1);
					default: hi = '1;
				endcase
			end else begin
				// well-formed range inside the tree
				lo = POS_BITS'($urandom_range(1, LEAVES));
				hi = POS_BITS'($urandom_range(lo + 1, LEAVES + 1));
			end

			send_word(op, pos, wval, lo, hi, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// drain owed sums, then allow a trailing write to finish
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
